[design/slc_pkg.sv]
package slc_pkg;

  localparam int COORD_W   = 16;
  localparam int DIM_W     = 13;
  localparam int STAT_W    = 3;
  localparam int CNT_W     = 14;
  localparam int STEP_W    = 16;
  localparam int CFG_IDX_W = 1;

  // Width used for the border selection arithmetic.
  localparam int SEL_W = 20;

  // Intercept divider: magnitude of 2n+d over 2|d|, quotient saturated.
  localparam int RDIV_N_W = 38;
  localparam int RDIV_D_W = 18;
  localparam int RDIV_Q_W = 18;

  typedef logic [STAT_W-1:0]           status_t;
  typedef logic signed [COORD_W-1:0]   coord_t;
  typedef logic [DIM_W-1:0]            dim_t;
  typedef logic [CFG_IDX_W-1:0]        cfg_idx_t;

  localparam status_t ST_OK         = 3'd0;
  localparam status_t ST_X_RANGE    = 3'd1;
  localparam status_t ST_Y_RANGE    = 3'd2;
  localparam status_t ST_SHORT      = 3'd3;
  localparam status_t ST_NO_OVERLAP = 3'd4;

  localparam cfg_idx_t REG_GRID_WIDTH  = 1'b0;
  localparam cfg_idx_t REG_GRID_HEIGHT = 1'b1;

  localparam dim_t GRID_RESET = 13'd256;

  localparam logic signed [STEP_W-1:0] STEP_ONE = 16'sd16384;
  localparam logic [CNT_W-1:0]         CNT_MAX  = 14'd16383;

  typedef struct packed {
    coord_t sx;
    coord_t sy;
    coord_t ex;
    coord_t ey;
  } seg_t;

  typedef struct packed {
    logic    valid;
    status_t status;
    seg_t    seg;
  } clip_res_t;

  typedef struct packed {
    status_t                    status;
    seg_t                       seg;
    logic [CNT_W-1:0]           count;
    logic signed [STEP_W-1:0]   step_x;
    logic signed [STEP_W-1:0]   step_y;
  } res_t;

  typedef struct packed {
    logic valid;
    res_t res;
  } meas_out_t;

  function automatic coord_t sat16(input logic signed [SEL_W-1:0] v);
    coord_t r;
    if (v > SEL_W'(32767)) begin
      r = 16'sh7FFF;
    end else if (v < -SEL_W'(32768)) begin
      r = 16'sh8000;
    end else begin
      r = v[COORD_W-1:0];
    end
    return r;
  endfunction

endpackage

[design/slc_if.sv]
interface slc_seg_if import slc_pkg::*; ();
  logic   valid;
  logic   ready;
  coord_t start_x;
  coord_t start_y;
  coord_t end_x;
  coord_t end_y;

  modport source(output valid, start_x, start_y, end_x, end_y, input ready);
  modport sink(input valid, start_x, start_y, end_x, end_y, output ready);
endinterface

interface slc_res_if import slc_pkg::*; ();
  logic                     valid;
  logic                     ready;
  status_t                  status;
  coord_t                   clip_start_x;
  coord_t                   clip_start_y;
  coord_t                   clip_end_x;
  coord_t                   clip_end_y;
  logic [CNT_W-1:0]         point_count;
  logic signed [STEP_W-1:0] step_x;
  logic signed [STEP_W-1:0] step_y;

  modport source(output valid, status, clip_start_x, clip_start_y, clip_end_x, clip_end_y,
                 point_count, step_x, step_y, input ready);
  modport sink(input valid, status, clip_start_x, clip_start_y, clip_end_x, clip_end_y,
               point_count, step_x, step_y, output ready);
endinterface

interface slc_cfg_if import slc_pkg::*; ();
  logic     valid;
  logic     ready;
  cfg_idx_t index;
  dim_t     data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

[design/slc_delay.sv]
module slc_delay import slc_pkg::*; #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic [WIDTH-1:0] d,
  output logic [WIDTH-1:0] q
);

  logic [WIDTH-1:0] line_r [DEPTH];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DEPTH; i++) begin
        line_r[i] <= '0;
      end
    end else if (en) begin
      line_r[0] <= d;
      for (int i = 1; i < DEPTH; i++) begin
        line_r[i] <= line_r[i-1];
      end
    end
  end

  assign q = line_r[DEPTH-1];

endmodule

[design/slc_div.sv]
module slc_div import slc_pkg::*; #(
  parameter int N_W = 38,
  parameter int D_W = 18,
  parameter int Q_W = 18
) (
  input  logic           clk,
  input  logic           en,
  input  logic [N_W-1:0] num,
  input  logic [D_W-1:0] den,
  output logic [Q_W-1:0] quo
);

  localparam int T_W = (N_W > D_W + Q_W) ? N_W : D_W + Q_W;

  logic [T_W-1:0] rem_r [Q_W];
  logic [Q_W-1:0] quo_r [Q_W+1];
  logic           ovf_r [Q_W+1];
  logic [D_W-1:0] den_r [Q_W];
  logic           ovf;

  // A quotient that does not fit is flagged up front and saturated at the end.
  assign ovf = T_W'(num) >= (T_W'(den) << Q_W);

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= ovf ? '0 : T_W'(num);
      quo_r[0] <= '0;
      ovf_r[0] <= ovf;
      den_r[0] <= den;
    end
  end

  for (genvar k = 1; k <= Q_W; k++) begin : g_stage
    localparam int B = Q_W - k;
    logic [T_W-1:0] trial;
    logic           take;

    assign trial = T_W'(den_r[k-1]) << B;
    assign take  = rem_r[k-1] >= trial;

    always_ff @(posedge clk) begin
      if (en) begin
        quo_r[k] <= take ? (quo_r[k-1] | (Q_W'(1) << B)) : quo_r[k-1];
        ovf_r[k] <= ovf_r[k-1];
      end
    end

    if (k < Q_W) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[k] <= take ? rem_r[k-1] - trial : rem_r[k-1];
          den_r[k] <= den_r[k-1];
        end
      end
    end
  end

  assign quo = ovf_r[Q_W] ? '1 : quo_r[Q_W];

endmodule

[design/slc_sqrt.sv]
module slc_sqrt import slc_pkg::*; #(
  parameter int IN_W = 34
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic [IN_W-1:0]         rad,
  output logic [(IN_W+1)/2-1:0]   root
);

  localparam int R_W = (IN_W + 1) / 2;
  localparam int P_W = 2 * R_W;

  logic [P_W-1:0] rem_in  [R_W];
  logic [R_W-1:0] root_in [R_W];
  logic [P_W-1:0] rem_r   [R_W-1];
  logic [R_W-1:0] root_r  [R_W];

  // Remainder form: rem holds rad - root^2, so each bit needs a shift, a compare
  // and a subtract only.
  for (genvar k = 0; k < R_W; k++) begin : g_stage
    localparam int B = R_W - 1 - k;
    logic [P_W:0] trial;
    logic         take;

    if (k == 0) begin : g_first
      assign rem_in[k]  = P_W'(rad);
      assign root_in[k] = '0;
    end else begin : g_next
      assign rem_in[k]  = rem_r[k-1];
      assign root_in[k] = root_r[k-1];
    end

    assign trial = ((P_W+1)'(root_in[k]) << (B + 1)) | ((P_W+1)'(1) << (2 * B));
    assign take  = (P_W+1)'(rem_in[k]) >= trial;

    always_ff @(posedge clk) begin
      if (en) begin
        root_r[k] <= take ? (root_in[k] | (R_W'(1) << B)) : root_in[k];
      end
    end

    if (k < R_W - 1) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[k] <= take ? rem_in[k] - trial[P_W-1:0] : rem_in[k];
        end
      end
    end
  end

  assign root = root_r[R_W-1];

endmodule

[design/slc_clip.sv]
module slc_clip import slc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      en,
  input  logic      in_valid,
  input  seg_t      in_seg,
  input  dim_t      grid_w,
  input  dim_t      grid_h,
  output clip_res_t res
);

  localparam int DIV_LAT = RDIV_Q_W + 1;

  typedef struct packed {
    logic   valid;
    logic   sw;
    coord_t x1;
    coord_t y1;
    coord_t x2;
    coord_t y2;
  } sb_t;

  typedef struct packed {
    sb_t        sb;
    logic [3:0] neg;
  } dly_t;

  sb_t sb_a_r, sb_b_r, sb_c_r, sb_d_r;
  logic sw_a;

  logic signed [16:0] dx_b, dy_b;
  logic signed [17:0] wx_b, hy_b;
  logic signed [32:0] p_ydx_r, p_xdy_r;
  logic signed [34:0] p_wdy_r, p_hdx_r;
  logic signed [16:0] dx_b_r, dy_b_r, dx_c_r, dy_c_r;

  logic signed [35:0] n_c_r [4];

  logic signed [35:0] n_sel [4];
  logic signed [16:0] d_sel [4];
  logic [RDIV_N_W-1:0] mag_d [4];
  logic [RDIV_D_W-1:0] den_d [4];
  logic [3:0]          neg_d;
  logic [RDIV_N_W-1:0] mag_d_r [4];
  logic [RDIV_D_W-1:0] den_d_r [4];
  logic [3:0]          neg_d_r;

  logic [RDIV_Q_W-1:0] quo [4];
  dly_t                dly_in, dly_out;

  clip_res_t res_r;

  // Stage A: left-to-right order, vertical segments bottom-to-top.
  assign sw_a = (in_seg.ex < in_seg.sx) || (in_seg.ex == in_seg.sx && in_seg.sy > in_seg.ey);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sb_a_r <= '0;
    end else if (en) begin
      sb_a_r.valid <= in_valid;
      sb_a_r.sw    <= sw_a;
      sb_a_r.x1    <= sw_a ? in_seg.ex : in_seg.sx;
      sb_a_r.y1    <= sw_a ? in_seg.ey : in_seg.sy;
      sb_a_r.x2    <= sw_a ? in_seg.sx : in_seg.ex;
      sb_a_r.y2    <= sw_a ? in_seg.sy : in_seg.ey;
    end
  end

  // Stage B: the four intercept products.
  assign dx_b = 17'(sb_a_r.x2) - 17'(sb_a_r.x1);
  assign dy_b = 17'(sb_a_r.y2) - 17'(sb_a_r.y1);
  assign wx_b = 18'(signed'({1'b0, grid_w})) - 18'sd1 - 18'(sb_a_r.x1);
  assign hy_b = 18'(signed'({1'b0, grid_h})) - 18'sd1 - 18'(sb_a_r.y1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sb_b_r <= '0;
    end else if (en) begin
      sb_b_r <= sb_a_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_ydx_r <= 33'(sb_a_r.y1) * 33'(dx_b);
      p_xdy_r <= 33'(sb_a_r.x1) * 33'(dy_b);
      p_wdy_r <= 35'(wx_b) * 35'(dy_b);
      p_hdx_r <= 35'(hy_b) * 35'(dx_b);
      dx_b_r  <= dx_b;
      dy_b_r  <= dy_b;
    end
  end

  // Stage C: numerators of the left, bottom, right and top intercepts.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sb_c_r <= '0;
    end else if (en) begin
      sb_c_r <= sb_b_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n_c_r[0] <= 36'(p_ydx_r) - 36'(p_xdy_r);
      n_c_r[1] <= 36'(p_xdy_r) - 36'(p_ydx_r);
      n_c_r[2] <= 36'(p_ydx_r) + 36'(p_wdy_r);
      n_c_r[3] <= 36'(p_xdy_r) + 36'(p_hdx_r);
      dx_c_r   <= dx_b_r;
      dy_c_r   <= dy_b_r;
    end
  end

  // Stage D: rounding to nearest becomes a truncating divide of 2n+d by 2d.
  always_comb begin
    n_sel[0] = n_c_r[0];
    n_sel[1] = n_c_r[1];
    n_sel[2] = n_c_r[2];
    n_sel[3] = n_c_r[3];
    d_sel[0] = dx_c_r;
    d_sel[1] = dy_c_r;
    d_sel[2] = dx_c_r;
    d_sel[3] = dy_c_r;
  end

  for (genvar i = 0; i < 4; i++) begin : g_prep
    logic signed [36:0] nn;
    logic [16:0]        ad;
    logic signed [37:0] num;

    assign nn       = d_sel[i][16] ? -37'(n_sel[i]) : 37'(n_sel[i]);
    assign ad       = d_sel[i][16] ? 17'(-d_sel[i]) : 17'(d_sel[i]);
    assign num      = 38'(nn) + 38'(nn) + 38'(signed'({1'b0, ad}));
    assign neg_d[i] = num[37];
    assign mag_d[i] = num[37] ? RDIV_N_W'(-num) : RDIV_N_W'(num);
    assign den_d[i] = {ad, 1'b0};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sb_d_r <= '0;
    end else if (en) begin
      sb_d_r <= sb_c_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        mag_d_r[i] <= mag_d[i];
        den_d_r[i] <= den_d[i];
      end
      neg_d_r <= neg_d;
    end
  end

  for (genvar i = 0; i < 4; i++) begin : g_div
    slc_div #(
      .N_W(RDIV_N_W),
      .D_W(RDIV_D_W),
      .Q_W(RDIV_Q_W)
    ) u_div (
      .clk (clk),
      .en  (en),
      .num (mag_d_r[i]),
      .den (den_d_r[i]),
      .quo (quo[i])
    );
  end

  assign dly_in.sb  = sb_d_r;
  assign dly_in.neg = neg_d_r;

  slc_delay #(
    .WIDTH($bits(dly_t)),
    .DEPTH(DIV_LAT)
  ) u_sb_dly (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .d     (dly_in),
    .q     (dly_out)
  );

  // Stage E: pick the border points.
  logic signed [SEL_W-1:0] w1, v2, w3, v4, xa, ya, xb, yb, wv, hv;
  logic signed [SEL_W-1:0] bx, by, tx, ty;
  logic signed [SEL_W-1:0] qs [4];
  logic                    x1o, y1o, x2o, y2o;
  status_t                 st;

  for (genvar i = 0; i < 4; i++) begin : g_sign
    assign qs[i] = dly_out.neg[i] ? -SEL_W'(signed'({1'b0, quo[i]}))
                                  : SEL_W'(signed'({1'b0, quo[i]}));
  end

  assign w1 = qs[0];
  assign v2 = qs[1];
  assign w3 = qs[2];
  assign v4 = qs[3];
  assign xa = SEL_W'(dly_out.sb.x1);
  assign ya = SEL_W'(dly_out.sb.y1);
  assign xb = SEL_W'(dly_out.sb.x2);
  assign yb = SEL_W'(dly_out.sb.y2);
  assign wv = SEL_W'(signed'({1'b0, grid_w}));
  assign hv = SEL_W'(signed'({1'b0, grid_h}));

  assign x1o = xa < 0 || xa >= wv;
  assign y1o = ya < 0 || ya >= hv;
  assign x2o = xb < 0 || xb >= wv;
  assign y2o = yb < 0 || yb >= hv;

  always_comb begin
    st = ST_OK;
    bx = xa;
    by = ya;
    tx = xb;
    ty = yb;
    if ((xa < 0 && xb < 0) || (xa >= wv && xb >= wv)) begin
      st = ST_X_RANGE;
    end else if ((ya < 0 && yb < 0) || (ya >= hv && yb >= hv)) begin
      st = ST_Y_RANGE;
    end else if (xa == xb && ya == yb) begin
      st = ST_SHORT;
    end else if (xa == xb) begin
      if (x1o) begin
        st = ST_X_RANGE;
      end else begin
        if (y1o) by = '0;
        if (y2o) ty = hv - 1;
      end
    end else if (ya == yb) begin
      if (y1o) begin
        st = ST_Y_RANGE;
      end else begin
        if (x1o) bx = '0;
        if (x2o) tx = wv - 1;
      end
    end else if (yb > ya) begin
      if (v2 < 0) begin
        if (w1 >= hv) begin
          st = ST_NO_OVERLAP;
        end else begin
          bx = '0;
          by = w1;
          if (w3 < hv) begin
            tx = wv - 1;
            ty = w3;
          end else begin
            tx = v4;
            ty = hv - 1;
          end
        end
      end else if (v2 >= wv) begin
        st = ST_NO_OVERLAP;
      end else begin
        bx = v2;
        by = '0;
        if (v4 < wv) begin
          tx = v4;
          ty = hv - 1;
        end else begin
          tx = wv - 1;
          ty = w3;
        end
      end
    end else begin
      if (v4 < 0) begin
        if (w1 <= 0) begin
          st = ST_NO_OVERLAP;
        end else begin
          bx = '0;
          by = w1;
          if (w3 > 0) begin
            tx = wv - 1;
            ty = w3;
          end else begin
            tx = v2;
            ty = '0;
          end
        end
      end else if (v4 >= wv) begin
        st = ST_NO_OVERLAP;
      end else begin
        bx = v4;
        by = hv - 1;
        if (v2 < wv) begin
          tx = v2;
          ty = '0;
        end else begin
          tx = wv - 1;
          ty = w3;
        end
      end
    end
    // Endpoints already on the grid are kept as they are.
    if (!x1o && !y1o) begin
      bx = xa;
      by = ya;
    end
    if (!x2o && !y2o) begin
      tx = xb;
      ty = yb;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_r <= '0;
    end else if (en) begin
      res_r.valid  <= dly_out.sb.valid;
      res_r.status <= st;
      res_r.seg.sx <= sat16(dly_out.sb.sw ? tx : bx);
      res_r.seg.sy <= sat16(dly_out.sb.sw ? ty : by);
      res_r.seg.ex <= sat16(dly_out.sb.sw ? bx : tx);
      res_r.seg.ey <= sat16(dly_out.sb.sw ? by : ty);
    end
  end

  assign res = res_r;

endmodule

[design/slc_meas.sv]
module slc_meas import slc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      en,
  input  clip_res_t clip,
  output meas_out_t res
);

  localparam int S_W      = 34;
  localparam int DQ_N_W   = 63;
  localparam int DQ_Q_W   = 31;
  localparam int SR_W     = (S_W + 1) / 2;
  localparam int QR_W     = (DQ_Q_W + 1) / 2;
  localparam int DIV_LAT  = DQ_Q_W + 1;
  localparam int SQ_LAT   = SR_W;
  localparam int QS_LAT   = QR_W;
  localparam int ROOT_DLY = DIV_LAT + QS_LAT - SQ_LAT;

  typedef struct packed {
    logic    valid;
    status_t status;
    seg_t    seg;
    logic    vert;
    logic    dec;
  } sb1_t;

  typedef struct packed {
    sb1_t sb;
    logic negx;
    logic negy;
    logic s_zero;
  } sb3_t;

  sb1_t sb1_r, sb2_r;
  sb3_t sb3_r, sb_out;
  logic signed [17:0] dx1_r, dy1_r;
  logic signed [35:0] sqx_full, sqy_full;
  logic [32:0]        sqx_r, sqy_r;
  logic               negx2_r, negy2_r;
  logic [S_W-1:0]     s_nxt, s_r;
  logic [DQ_N_W-1:0]  nx_r, ny_r;

  logic [SR_W-1:0]    root_s, root_s_d;
  logic [DQ_Q_W-1:0]  qx, qy;
  logic [QR_W-1:0]    rqx, rqy;

  meas_out_t res_r;

  // Stage 1: differences, one added as in the count formula.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sb1_r <= '0;
    end else if (en) begin
      sb1_r.valid  <= clip.valid;
      sb1_r.status <= clip.status;
      sb1_r.seg    <= clip.seg;
      sb1_r.vert   <= clip.seg.sx == clip.seg.ex;
      sb1_r.dec    <= clip.seg.sy > clip.seg.ey;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dx1_r <= 18'(clip.seg.ex) - 18'(clip.seg.sx) + 18'sd1;
      dy1_r <= 18'(clip.seg.ey) - 18'(clip.seg.sy) + 18'sd1;
    end
  end

  // Stage 2: squares.
  assign sqx_full = 36'(dx1_r) * 36'(dx1_r);
  assign sqy_full = 36'(dy1_r) * 36'(dy1_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sb2_r <= '0;
    end else if (en) begin
      sb2_r <= sb1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sqx_r   <= sqx_full[32:0];
      sqy_r   <= sqy_full[32:0];
      negx2_r <= dx1_r[17];
      negy2_r <= dy1_r[17];
    end
  end

  // Stage 3: squared length, and d^2 * 2^30 for the step quotients.
  assign s_nxt = S_W'(sqx_r) + S_W'(sqy_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sb3_r <= '0;
    end else if (en) begin
      sb3_r.sb     <= sb2_r;
      sb3_r.negx   <= negx2_r;
      sb3_r.negy   <= negy2_r;
      sb3_r.s_zero <= s_nxt == '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s_r  <= s_nxt;
      nx_r <= {sqx_r, 30'b0};
      ny_r <= {sqy_r, 30'b0};
    end
  end

  slc_sqrt #(.IN_W(S_W)) u_len_sqrt (
    .clk  (clk),
    .en   (en),
    .rad  (s_r),
    .root (root_s)
  );

  slc_delay #(
    .WIDTH(SR_W),
    .DEPTH(ROOT_DLY)
  ) u_len_dly (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .d     (root_s),
    .q     (root_s_d)
  );

  // The rounded step magnitude is floor((isqrt(floor(d^2 * 2^30 / s)) + 1) / 2).
  slc_div #(.N_W(DQ_N_W), .D_W(S_W), .Q_W(DQ_Q_W)) u_div_x (
    .clk (clk),
    .en  (en),
    .num (nx_r),
    .den (s_r),
    .quo (qx)
  );

  slc_div #(.N_W(DQ_N_W), .D_W(S_W), .Q_W(DQ_Q_W)) u_div_y (
    .clk (clk),
    .en  (en),
    .num (ny_r),
    .den (s_r),
    .quo (qy)
  );

  slc_sqrt #(.IN_W(DQ_Q_W)) u_sqrt_x (
    .clk  (clk),
    .en   (en),
    .rad  (qx),
    .root (rqx)
  );

  slc_sqrt #(.IN_W(DQ_Q_W)) u_sqrt_y (
    .clk  (clk),
    .en   (en),
    .rad  (qy),
    .root (rqy)
  );

  slc_delay #(
    .WIDTH($bits(sb3_t)),
    .DEPTH(DIV_LAT + QS_LAT)
  ) u_sb_dly (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .d     (sb3_r),
    .q     (sb_out)
  );

  logic [SR_W:0]            cnt_w;
  logic [QR_W:0]            mx, my;
  logic signed [STEP_W-1:0] stx, sty;
  res_t                     fin;

  assign cnt_w = (SR_W+1)'(root_s_d) + (SR_W+1)'(1);
  assign mx    = ((QR_W+1)'(rqx) + (QR_W+1)'(1)) >> 1;
  assign my    = ((QR_W+1)'(rqy) + (QR_W+1)'(1)) >> 1;
  assign stx   = sb_out.negx ? -STEP_W'(mx) : STEP_W'(mx);
  assign sty   = sb_out.negy ? -STEP_W'(my) : STEP_W'(my);

  always_comb begin
    fin = '0;
    if (sb_out.sb.status != ST_OK) begin
      fin.status = sb_out.sb.status;
    end else begin
      fin.status = ST_OK;
      fin.seg    = sb_out.sb.seg;
      fin.count  = (cnt_w > (SR_W+1)'(CNT_MAX)) ? CNT_MAX : cnt_w[CNT_W-1:0];
      if (sb_out.sb.vert) begin
        fin.step_x = '0;
        fin.step_y = sb_out.sb.dec ? -STEP_ONE : STEP_ONE;
      end else if (sb_out.s_zero) begin
        fin.step_x = STEP_ONE;
        fin.step_y = '0;
      end else begin
        fin.step_x = stx;
        fin.step_y = sty;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_r <= '0;
    end else if (en) begin
      res_r.valid <= sb_out.sb.valid;
      res_r.res   <= fin;
    end
  end

  assign res = res_r;

endmodule

[design/slice_line_clip_and_step_unit.sv]
// Clips one segment per transfer to the configured grid and measures the clipped
// segment: point count and a Q1.14 unit step. One segment can be taken every clock
// while the skid register is empty. A result passes the clipping front end (intercept
// products, four 18-bit restoring dividers: 24 stages), the measurement (length root,
// step dividers and roots: 52 stages) and the output register. The whole pipeline
// advances together and holds only while a second result waits in the output skid
// register. Grid width and height, clamped to 1..MAX_DIM, must be written through the
// configuration port while no segment is in flight; the block does not enforce this.
module slice_line_clip_and_step_unit import slc_pkg::*; #(
  parameter int MAX_DIM = 4096
) (
  input logic        clk,
  input logic        rst_n,
  slc_seg_if.sink    in_seg,
  slc_res_if.source  out_res,
  slc_cfg_if.sink    cfg_wr
);

  dim_t      grid_w_r, grid_h_r;
  logic      en;
  seg_t      seg_in;
  clip_res_t clip_res;
  meas_out_t meas_res;

  logic out_valid_r, out_valid_nxt;
  logic skid_valid_r, skid_valid_nxt;
  res_t out_data_r, out_data_nxt;
  res_t skid_data_r, skid_data_nxt;
  logic push, pop;

  function automatic dim_t clamp_dim(input dim_t v);
    dim_t r;
    r = v;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (int'(v) > MAX_DIM) begin
      r = DIM_W'(MAX_DIM);
    end
    return r;
  endfunction

  assign cfg_wr.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_w_r <= GRID_RESET;
      grid_h_r <= GRID_RESET;
    end else if (cfg_wr.valid) begin
      case (cfg_wr.index)
        REG_GRID_WIDTH:  grid_w_r <= clamp_dim(cfg_wr.data);
        REG_GRID_HEIGHT: grid_h_r <= clamp_dim(cfg_wr.data);
        default: ;
      endcase
    end
  end

  assign en           = !skid_valid_r;
  assign in_seg.ready = en;

  assign seg_in.sx = in_seg.start_x;
  assign seg_in.sy = in_seg.start_y;
  assign seg_in.ex = in_seg.end_x;
  assign seg_in.ey = in_seg.end_y;

  slc_clip u_clip (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (in_seg.valid),
    .in_seg   (seg_in),
    .grid_w   (grid_w_r),
    .grid_h   (grid_h_r),
    .res      (clip_res)
  );

  slc_meas u_meas (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .clip  (clip_res),
    .res   (meas_res)
  );

  // Output register plus one skid entry; the pipeline stops only when the skid is full.
  assign push = en && meas_res.valid;
  assign pop  = out_valid_r && out_res.ready;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    skid_valid_nxt = skid_valid_r;
    skid_data_nxt  = skid_data_r;
    if (pop) begin
      if (skid_valid_r) begin
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end else begin
        out_valid_nxt = push;
        out_data_nxt  = meas_res.res;
      end
    end else if (push) begin
      if (!out_valid_r) begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = meas_res.res;
      end else begin
        skid_valid_nxt = 1'b1;
        skid_data_nxt  = meas_res.res;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign out_res.valid        = out_valid_r;
  assign out_res.status       = out_data_r.status;
  assign out_res.clip_start_x = out_data_r.seg.sx;
  assign out_res.clip_start_y = out_data_r.seg.sy;
  assign out_res.clip_end_x   = out_data_r.seg.ex;
  assign out_res.clip_end_y   = out_data_r.seg.ey;
  assign out_res.point_count  = out_data_r.count;
  assign out_res.step_x       = out_data_r.step_x;
  assign out_res.step_y       = out_data_r.step_y;

`ifndef SYNTHESIS
  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry held without a result in the output register");

  a_skid_cause: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> $past(out_valid_r && !out_res.ready))
    else $error("skid entry present although the output was not stalled");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.status != ST_OK) |->
      (out_data_r.count == '0 && out_data_r.step_x == '0 && out_data_r.step_y == '0))
    else $error("failed segment carries a nonzero count or step");

  a_vertical_step: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.status == ST_OK && out_data_r.seg.sx == out_data_r.seg.ex)
      |-> out_data_r.step_x == '0)
    else $error("vertical segment with a nonzero x step");
`endif

endmodule
